// ===== hdl/bioheat_stencil_cell_update_defines.svh =====
// Assertion macros shared by the bioheat stencil cell update RTL.
`ifndef BIOHEAT_STENCIL_CELL_UPDATE_DEFINES_SVH
`define BIOHEAT_STENCIL_CELL_UPDATE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define BSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define BSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bsc_pkg.sv =====
// Package with widths, register codes, reset values and types of the cell update.
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

  localparam int TEMP_W    = 15;
  localparam int DCOEF_W   = 22;
  localparam int RATE_W    = 32;
  localparam int PERF_W    = 16;
  localparam int STEADY_W  = 20;
  localparam int NANO_W    = 20;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int NUM_FACES = 4;

  localparam int DIFF_W  = TEMP_W + 1;
  localparam int TERM_W  = DCOEF_W + 1 + DIFF_W;
  localparam int PAIR_W  = TERM_W + 1;
  localparam int SUM_W   = PAIR_W + 1;
  localparam int M_W     = SUM_W - 1;
  localparam int PT_W    = PERF_W + TEMP_W;
  localparam int SRC_W   = STEADY_W + 8 + 1;
  localparam int C_W     = PT_W + 2;
  localparam int M_SPLIT = 20;
  localparam int MH_W    = M_W - M_SPLIT;
  localparam int PPH_W   = MH_W + RATE_W;
  localparam int PPL_W   = M_SPLIT + RATE_W;
  localparam int PROD_W  = M_W + RATE_W;
  localparam int RND_POS = 48;
  localparam int INC_W   = PROD_W + 1 - RND_POS;
  localparam int RES_W   = INC_W + 2;
  localparam int PIPE_LAT = 8;

  localparam int DIV_NUM_W = 2 * DCOEF_W + 3;
  localparam int DIV_DEN_W = DCOEF_W + 2;
  localparam int DIV_SUM_W = DCOEF_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [PROD_W:0] ROUND_K = (PROD_W + 1)'(1) << (RND_POS - 1);
  localparam logic [TEMP_W-1:0] TEMP_MAX = {TEMP_W{1'b1}};

  localparam logic TIS_HEALTHY = 1'b0;
  localparam logic TIS_TUMOUR  = 1'b1;

  typedef enum logic [2:0] {
    REG_DIFF_H   = 3'd0,
    REG_DIFF_T   = 3'd1,
    REG_RATE_H   = 3'd2,
    REG_RATE_T   = 3'd3,
    REG_PERF_H   = 3'd4,
    REG_PERF_T   = 3'd5,
    REG_STEADY_H = 3'd6,
    REG_STEADY_T = 3'd7
  } bsc_reg_t;

  localparam logic [DCOEF_W-1:0]  RST_DIFF_H   = 22'd500000;
  localparam logic [DCOEF_W-1:0]  RST_DIFF_T   = 22'd550000;
  localparam logic [RATE_W-1:0]   RST_RATE_H   = 32'd33508418;
  localparam logic [RATE_W-1:0]   RST_RATE_T   = 32'd32570573;
  localparam logic [PERF_W-1:0]   RST_PERF_H   = 16'd2100;
  localparam logic [PERF_W-1:0]   RST_PERF_T   = 16'd5250;
  localparam logic [STEADY_W-1:0] RST_STEADY_H = 20'd81900;
  localparam logic [STEADY_W-1:0] RST_STEADY_T = 20'd194670;

  typedef struct packed {
    logic [DCOEF_W-1:0]  diff_h;
    logic [DCOEF_W-1:0]  diff_t;
    logic [RATE_W-1:0]   rate_h;
    logic [RATE_W-1:0]   rate_t;
    logic [PERF_W-1:0]   perf_h;
    logic [PERF_W-1:0]   perf_t;
    logic [STEADY_W-1:0] steady_h;
    logic [STEADY_W-1:0] steady_t;
  } bsc_cfg_t;

  typedef struct packed {
    logic               busy;
    logic [DCOEF_W-1:0] g_mix;
  } bsc_cond_t;

endpackage
`default_nettype wire

// ===== hdl/bsc_cfg_regs.sv =====
// Configuration register file with an APB-style write and read port.
`timescale 1ns / 1ps
`default_nettype none
module bsc_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bsc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bsc_pkg::DATA_W-1:0]   pwdata,
  output logic      [bsc_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output bsc_pkg::bsc_cfg_t                 cfg,
  output logic                              cond_wr
);

  bsc_pkg::bsc_cfg_t cfg_r;
  bsc_pkg::bsc_reg_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = bsc_pkg::bsc_reg_t'(paddr[bsc_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_comb begin
    cond_wr = wr_en && (idx inside {bsc_pkg::REG_DIFF_H, bsc_pkg::REG_DIFF_T});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.diff_h   <= bsc_pkg::RST_DIFF_H;
      cfg_r.diff_t   <= bsc_pkg::RST_DIFF_T;
      cfg_r.rate_h   <= bsc_pkg::RST_RATE_H;
      cfg_r.rate_t   <= bsc_pkg::RST_RATE_T;
      cfg_r.perf_h   <= bsc_pkg::RST_PERF_H;
      cfg_r.perf_t   <= bsc_pkg::RST_PERF_T;
      cfg_r.steady_h <= bsc_pkg::RST_STEADY_H;
      cfg_r.steady_t <= bsc_pkg::RST_STEADY_T;
    end else if (wr_en) begin
      case (idx)
        bsc_pkg::REG_DIFF_H:   cfg_r.diff_h   <= pwdata[bsc_pkg::DCOEF_W-1:0];
        bsc_pkg::REG_DIFF_T:   cfg_r.diff_t   <= pwdata[bsc_pkg::DCOEF_W-1:0];
        bsc_pkg::REG_RATE_H:   cfg_r.rate_h   <= pwdata[bsc_pkg::RATE_W-1:0];
        bsc_pkg::REG_RATE_T:   cfg_r.rate_t   <= pwdata[bsc_pkg::RATE_W-1:0];
        bsc_pkg::REG_PERF_H:   cfg_r.perf_h   <= pwdata[bsc_pkg::PERF_W-1:0];
        bsc_pkg::REG_PERF_T:   cfg_r.perf_t   <= pwdata[bsc_pkg::PERF_W-1:0];
        bsc_pkg::REG_STEADY_H: cfg_r.steady_h <= pwdata[bsc_pkg::STEADY_W-1:0];
        bsc_pkg::REG_STEADY_T: cfg_r.steady_t <= pwdata[bsc_pkg::STEADY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bsc_pkg::REG_DIFF_H:   prdata = bsc_pkg::DATA_W'(cfg_r.diff_h);
      bsc_pkg::REG_DIFF_T:   prdata = bsc_pkg::DATA_W'(cfg_r.diff_t);
      bsc_pkg::REG_RATE_H:   prdata = bsc_pkg::DATA_W'(cfg_r.rate_h);
      bsc_pkg::REG_RATE_T:   prdata = bsc_pkg::DATA_W'(cfg_r.rate_t);
      bsc_pkg::REG_PERF_H:   prdata = bsc_pkg::DATA_W'(cfg_r.perf_h);
      bsc_pkg::REG_PERF_T:   prdata = bsc_pkg::DATA_W'(cfg_r.perf_t);
      bsc_pkg::REG_STEADY_H: prdata = bsc_pkg::DATA_W'(cfg_r.steady_h);
      bsc_pkg::REG_STEADY_T: prdata = bsc_pkg::DATA_W'(cfg_r.steady_t);
      default:               prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/bsc_harm_div.sv =====
// Sequential divider that forms the mixed-tissue face conductance from the two coefficients.
`timescale 1ns / 1ps
`default_nettype none
module bsc_harm_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [bsc_pkg::DCOEF_W-1:0]   coef_h,
  input  wire logic [bsc_pkg::DCOEF_W-1:0]   coef_t,
  input  wire logic                          recalc,
  output bsc_pkg::bsc_cond_t                 cond
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;

  state_t                            state_r;
  logic                              req_r;
  logic [2*bsc_pkg::DCOEF_W-1:0]     prod_r;
  logic [bsc_pkg::DIV_SUM_W-1:0]     sum_r;
  logic [bsc_pkg::DIV_NUM_W-1:0]     num_r;
  logic [bsc_pkg::DIV_DEN_W-1:0]     den_r;
  logic [bsc_pkg::DIV_DEN_W-1:0]     rem_r;
  logic [bsc_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [bsc_pkg::DCOEF_W-1:0]       g_r;
  logic [bsc_pkg::DIV_DEN_W:0]       rem_sh;
  logic [bsc_pkg::DIV_DEN_W:0]       rem_dif;
  logic [bsc_pkg::DIV_DEN_W-1:0]     rem_nxt;
  logic                              q_bit;

  // One quotient bit per cycle: g = (4ab + a + b) / (2(a + b)).
  always_comb begin
    rem_sh  = {rem_r, num_r[bsc_pkg::DIV_NUM_W-1]};
    rem_dif = rem_sh - {1'b0, den_r};
    q_bit   = (rem_sh >= {1'b0, den_r});
    rem_nxt = q_bit ? rem_dif[bsc_pkg::DIV_DEN_W-1:0] : rem_sh[bsc_pkg::DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      req_r   <= 1'b1;
    end else begin
      req_r <= recalc | (req_r & (state_r != ST_IDLE));
      case (state_r)
        ST_IDLE: begin
          if (req_r) begin
            prod_r  <= coef_h * coef_t;
            sum_r   <= {1'b0, coef_h} + {1'b0, coef_t};
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          num_r   <= {1'b0, prod_r, 2'b00} + bsc_pkg::DIV_NUM_W'(sum_r);
          den_r   <= {sum_r, 1'b0};
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= rem_nxt;
          num_r <= {num_r[bsc_pkg::DIV_NUM_W-2:0], q_bit};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == bsc_pkg::DIV_CNT_W'(bsc_pkg::DIV_NUM_W - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          g_r     <= (den_r == '0) ? '0 : num_r[bsc_pkg::DCOEF_W-1:0];
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign cond.busy  = req_r | (state_r != ST_IDLE);
  assign cond.g_mix = g_r;

endmodule
`default_nettype wire

// ===== hdl/bsc_pipe.sv =====
// Eight-stage datapath: conductance select, products, heat sum, rate multiply, round and clip.
`timescale 1ns / 1ps
`default_nettype none
module bsc_pipe (
  input  wire logic                                                clk,
  input  wire logic                                                rst_n,
  input  wire logic                                                in_valid,
  input  wire logic [bsc_pkg::TEMP_W-1:0]                          temp_c,
  input  wire logic [bsc_pkg::NUM_FACES-1:0][bsc_pkg::TEMP_W-1:0]  temp_nb,
  input  wire logic                                                tis_c,
  input  wire logic [bsc_pkg::NUM_FACES-1:0]                       tis_nb,
  input  wire logic [bsc_pkg::NANO_W-1:0]                          nano,
  input  wire bsc_pkg::bsc_cfg_t                                   cfg,
  input  wire logic [bsc_pkg::DCOEF_W-1:0]                         g_mix,
  output logic                                                     out_valid,
  output logic [bsc_pkg::TEMP_W-1:0]                               out_temp,
  output logic                                                     out_sat
);

  // Stage 1: face conductances, temperature differences, centre tissue parameters.
  logic                                                 v1_r;
  logic [bsc_pkg::NUM_FACES-1:0][bsc_pkg::DCOEF_W-1:0]  g1_r;
  logic signed [bsc_pkg::DIFF_W-1:0]                    d1_r [bsc_pkg::NUM_FACES];
  logic [bsc_pkg::TEMP_W-1:0]                           tc1_r;
  logic [bsc_pkg::RATE_W-1:0]                           rate1_r;
  logic [bsc_pkg::PERF_W-1:0]                           perf1_r;
  logic [bsc_pkg::STEADY_W-1:0]                         steady1_r;
  logic [bsc_pkg::NANO_W-1:0]                           nano1_r;
  logic [bsc_pkg::NUM_FACES-1:0][bsc_pkg::DCOEF_W-1:0]  g1_nxt;

  // Stage 2: products.
  logic                                   v2_r;
  logic signed [bsc_pkg::TERM_W-1:0]      term2_r [bsc_pkg::NUM_FACES];
  logic [bsc_pkg::PT_W-1:0]               pt2_r;
  logic [bsc_pkg::SRC_W-1:0]              src2_r;
  logic [bsc_pkg::TEMP_W-1:0]             tc2_r;
  logic [bsc_pkg::RATE_W-1:0]             rate2_r;

  // Stage 3: partial sums.
  logic                                   v3_r;
  logic signed [bsc_pkg::PAIR_W-1:0]      pa3_r;
  logic signed [bsc_pkg::PAIR_W-1:0]      pb3_r;
  logic signed [bsc_pkg::C_W-1:0]         c3_r;
  logic [bsc_pkg::TEMP_W-1:0]             tc3_r;
  logic [bsc_pkg::RATE_W-1:0]             rate3_r;

  // Stage 4: heat sum.
  logic                                   v4_r;
  logic signed [bsc_pkg::SUM_W-1:0]       s4_r;
  logic [bsc_pkg::TEMP_W-1:0]             tc4_r;
  logic [bsc_pkg::RATE_W-1:0]             rate4_r;

  // Stage 5: magnitude and sign.
  logic                                   v5_r;
  logic [bsc_pkg::M_W-1:0]                m5_r;
  logic                                   neg5_r;
  logic [bsc_pkg::TEMP_W-1:0]             tc5_r;
  logic [bsc_pkg::RATE_W-1:0]             rate5_r;
  logic signed [bsc_pkg::SUM_W-1:0]       abs5_nxt;

  // Stage 6: partial products of magnitude times rate.
  logic                                   v6_r;
  logic [bsc_pkg::PPH_W-1:0]              pph6_r;
  logic [bsc_pkg::PPL_W-1:0]              ppl6_r;
  logic                                   neg6_r;
  logic [bsc_pkg::TEMP_W-1:0]             tc6_r;

  // Stage 7: rounded increment.
  logic                                   v7_r;
  logic [bsc_pkg::INC_W-1:0]              inc7_r;
  logic                                   neg7_r;
  logic [bsc_pkg::TEMP_W-1:0]             tc7_r;
  logic [bsc_pkg::PROD_W:0]               full7_nxt;

  // Stage 8: output registers.
  logic                                   out_valid_r;
  logic [bsc_pkg::TEMP_W-1:0]             out_temp_r;
  logic                                   out_sat_r;
  logic signed [bsc_pkg::RES_W-1:0]       t8_nxt;
  logic [bsc_pkg::TEMP_W-1:0]             temp8_nxt;
  logic                                   sat8_nxt;

  always_comb begin
    for (int f = 0; f < bsc_pkg::NUM_FACES; f++) begin
      if (tis_c != tis_nb[f]) begin
        g1_nxt[f] = g_mix;
      end else if (tis_c == bsc_pkg::TIS_TUMOUR) begin
        g1_nxt[f] = cfg.diff_t;
      end else begin
        g1_nxt[f] = cfg.diff_h;
      end
    end
  end

  always_comb begin
    abs5_nxt = s4_r[bsc_pkg::SUM_W-1] ? -s4_r : s4_r;
  end

  always_comb begin
    full7_nxt = {1'b0, pph6_r, {bsc_pkg::M_SPLIT{1'b0}}}
              + (bsc_pkg::PROD_W + 1)'(ppl6_r) + bsc_pkg::ROUND_K;
  end

  always_comb begin
    if (neg7_r) begin
      t8_nxt = bsc_pkg::RES_W'(tc7_r) - bsc_pkg::RES_W'(inc7_r);
    end else begin
      t8_nxt = bsc_pkg::RES_W'(tc7_r) + bsc_pkg::RES_W'(inc7_r);
    end
    if (t8_nxt[bsc_pkg::RES_W-1]) begin
      temp8_nxt = '0;
      sat8_nxt  = 1'b1;
    end else if (t8_nxt[bsc_pkg::RES_W-2:bsc_pkg::TEMP_W] != '0) begin
      temp8_nxt = bsc_pkg::TEMP_MAX;
      sat8_nxt  = 1'b1;
    end else begin
      temp8_nxt = t8_nxt[bsc_pkg::TEMP_W-1:0];
      sat8_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    g1_r      <= g1_nxt;
    for (int f = 0; f < bsc_pkg::NUM_FACES; f++) begin
      d1_r[f] <= $signed({1'b0, temp_nb[f]}) - $signed({1'b0, temp_c});
    end
    tc1_r     <= temp_c;
    rate1_r   <= (tis_c == bsc_pkg::TIS_TUMOUR) ? cfg.rate_t : cfg.rate_h;
    perf1_r   <= (tis_c == bsc_pkg::TIS_TUMOUR) ? cfg.perf_t : cfg.perf_h;
    steady1_r <= (tis_c == bsc_pkg::TIS_TUMOUR) ? cfg.steady_t : cfg.steady_h;
    nano1_r   <= nano;

    for (int f = 0; f < bsc_pkg::NUM_FACES; f++) begin
      term2_r[f] <= $signed({1'b0, g1_r[f]}) * d1_r[f];
    end
    pt2_r   <= perf1_r * tc1_r;
    src2_r  <= {1'b0, steady1_r, 8'd0} + {1'b0, nano1_r, 8'd0};
    tc2_r   <= tc1_r;
    rate2_r <= rate1_r;

    pa3_r   <= bsc_pkg::PAIR_W'(term2_r[0]) + bsc_pkg::PAIR_W'(term2_r[1]);
    pb3_r   <= bsc_pkg::PAIR_W'(term2_r[2]) + bsc_pkg::PAIR_W'(term2_r[3]);
    c3_r    <= $signed(bsc_pkg::C_W'(src2_r)) - $signed(bsc_pkg::C_W'(pt2_r));
    tc3_r   <= tc2_r;
    rate3_r <= rate2_r;

    s4_r    <= bsc_pkg::SUM_W'(pa3_r) + bsc_pkg::SUM_W'(pb3_r) + bsc_pkg::SUM_W'(c3_r);
    tc4_r   <= tc3_r;
    rate4_r <= rate3_r;

    m5_r    <= abs5_nxt[bsc_pkg::M_W-1:0];
    neg5_r  <= s4_r[bsc_pkg::SUM_W-1];
    tc5_r   <= tc4_r;
    rate5_r <= rate4_r;

    pph6_r  <= m5_r[bsc_pkg::M_W-1:bsc_pkg::M_SPLIT] * rate5_r;
    ppl6_r  <= m5_r[bsc_pkg::M_SPLIT-1:0] * rate5_r;
    neg6_r  <= neg5_r;
    tc6_r   <= tc5_r;

    inc7_r  <= full7_nxt[bsc_pkg::PROD_W:bsc_pkg::RND_POS];
    neg7_r  <= neg6_r;
    tc7_r   <= tc6_r;

    out_temp_r <= temp8_nxt;
    out_sat_r  <= sat8_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_temp  = out_temp_r;
  assign out_sat   = out_sat_r;

endmodule
`default_nettype wire

// ===== hdl/bioheat_stencil_cell_update.sv =====
// Top level of the Pennes bioheat explicit update for one stencil cell.
//
//  Channel   Transfer when                       Carries
//  input     start high and busy low at edge     in_temp_*, in_tissue_*, in_nano_heat
//  result    out_valid high for one cycle        out_temp_next, out_saturated
//  config    psel, penable, pwrite, pready high  pwdata to register paddr[4:2]
//
// One cell enters per cycle while busy is low; its result transfer comes after the input transfer,
// through the eight register stages of the datapath.
// After reset, and after each write of a conductivity register, busy stays high while the
// one-bit-per-cycle divider forms the mixed-tissue conductance.
// Reset is synchronous and active low; results cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none
`include "bioheat_stencil_cell_update_defines.svh"
module bioheat_stencil_cell_update (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [bsc_pkg::TEMP_W-1:0]     in_temp_centre,
  input  wire logic [bsc_pkg::TEMP_W-1:0]     in_temp_row_before,
  input  wire logic [bsc_pkg::TEMP_W-1:0]     in_temp_row_after,
  input  wire logic [bsc_pkg::TEMP_W-1:0]     in_temp_col_before,
  input  wire logic [bsc_pkg::TEMP_W-1:0]     in_temp_col_after,
  input  wire logic                           in_tissue_centre,
  input  wire logic                           in_tissue_row_before,
  input  wire logic                           in_tissue_row_after,
  input  wire logic                           in_tissue_col_before,
  input  wire logic                           in_tissue_col_after,
  input  wire logic [bsc_pkg::NANO_W-1:0]     in_nano_heat,
  output logic                                out_valid,
  output logic [bsc_pkg::TEMP_W-1:0]          out_temp_next,
  output logic                                out_saturated,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bsc_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [bsc_pkg::DATA_W-1:0]     pwdata,
  output logic      [bsc_pkg::DATA_W-1:0]     prdata,
  output logic                                pready
);

  bsc_pkg::bsc_cfg_t                                        cfg;
  bsc_pkg::bsc_cond_t                                       cond;
  logic                                                     cond_wr;
  logic                                                     in_accept;
  logic [bsc_pkg::NUM_FACES-1:0][bsc_pkg::TEMP_W-1:0]       temp_nb;
  logic [bsc_pkg::NUM_FACES-1:0]                            tis_nb;

  assign busy      = cond.busy;
  assign in_accept = start & ~busy;
  assign temp_nb   = {in_temp_col_after, in_temp_col_before,
                      in_temp_row_after, in_temp_row_before};
  assign tis_nb    = {in_tissue_col_after, in_tissue_col_before,
                      in_tissue_row_after, in_tissue_row_before};

  bsc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cond_wr (cond_wr)
  );

  bsc_harm_div u_harm_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .coef_h (cfg.diff_h),
    .coef_t (cfg.diff_t),
    .recalc (cond_wr),
    .cond   (cond)
  );

  bsc_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_accept),
    .temp_c    (in_temp_centre),
    .temp_nb   (temp_nb),
    .tis_c     (in_tissue_centre),
    .tis_nb    (tis_nb),
    .nano      (in_nano_heat),
    .cfg       (cfg),
    .g_mix     (cond.g_mix),
    .out_valid (out_valid),
    .out_temp  (out_temp_next),
    .out_sat   (out_saturated)
  );

  `BSC_ASSERT_IMP(a_out_follows_in, out_valid, $past(in_accept, bsc_pkg::PIPE_LAT), "result transfer without a matching input transfer")
  `BSC_ASSERT_IMP(a_sat_at_limit, out_valid && out_saturated, (out_temp_next == '0) || (out_temp_next == bsc_pkg::TEMP_MAX), "clipped result is not at a range limit")
  `BSC_ASSERT_NXT(a_recalc_busy, cond_wr, busy, "conductivity write did not raise busy")

endmodule
`default_nettype wire

// ===== bench/tb_bioheat_stencil_cell_update.sv =====
// Self-checking testbench for the bioheat stencil cell update, with directed and random cells.
`timescale 1ns / 1ps
module tb_bioheat_stencil_cell_update;

  localparam int NUM_SETTINGS      = 6;
  localparam int CELLS_PER_SETTING = 306;
  localparam int STALL_LIMIT       = 2000;
  localparam logic [bsc_pkg::NANO_W-1:0] NANO_TOP = {bsc_pkg::NANO_W{1'b1}};

  typedef struct packed {
    logic [bsc_pkg::TEMP_W-1:0] centre, row_before, row_after, col_before, col_after;
    logic [4:0]                 labels;  // {centre, row_before, row_after, col_before, col_after}
    logic [bsc_pkg::NANO_W-1:0] nano;
  } cell_t;

  typedef struct packed {
    logic [bsc_pkg::TEMP_W-1:0] temp_next;
    logic                       saturated;
  } update_t;

  typedef struct {
    cell_t   stim;
    logic    known;
    update_t want;
  } cell_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [bsc_pkg::TEMP_W-1:0]   in_temp_centre = '0;
  logic [bsc_pkg::TEMP_W-1:0]   in_temp_row_before = '0;
  logic [bsc_pkg::TEMP_W-1:0]   in_temp_row_after = '0;
  logic [bsc_pkg::TEMP_W-1:0]   in_temp_col_before = '0;
  logic [bsc_pkg::TEMP_W-1:0]   in_temp_col_after = '0;
  logic                         in_tissue_centre = 1'b0;
  logic                         in_tissue_row_before = 1'b0;
  logic                         in_tissue_row_after = 1'b0;
  logic                         in_tissue_col_before = 1'b0;
  logic                         in_tissue_col_after = 1'b0;
  logic [bsc_pkg::NANO_W-1:0]   in_nano_heat = '0;
  logic                         out_valid;
  logic [bsc_pkg::TEMP_W-1:0]   out_temp_next;
  logic                         out_saturated;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [bsc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [bsc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [bsc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  logic [31:0] coef_shadow [8];
  update_t     pending_updates [$];
  int          mismatch_count = 0;
  int          cells_sent = 0;
  int          updates_checked = 0;
  int          clipped_count = 0;
  int          stall_cycles = 0;

  cell_row_t directed_rows [14] = '{
    '{'{0, 0, 0, 0, 0, 5'b00000, 0}, 1'b0, '{0, 0}},
    '{'{0, 0, 0, 0, 0, 5'b11111, 0}, 1'b0, '{0, 0}},
    '{'{32767, 32767, 32767, 32767, 32767, 5'b00000, 1048575}, 1'b1, '{32767, 1}},
    '{'{32767, 32767, 32767, 32767, 32767, 5'b11111, 1048575}, 1'b1, '{32767, 1}},
    '{'{9000, 9000, 9000, 9000, 9000, 5'b01111, 0}, 1'b0, '{0, 0}},
    '{'{9000, 9000, 9000, 9000, 9000, 5'b10000, 0}, 1'b0, '{0, 0}},
    '{'{9472, 9400, 9500, 9472, 9550, 5'b10110, 500000}, 1'b0, '{0, 0}},
    '{'{32767, 0, 0, 0, 0, 5'b00000, 0}, 1'b0, '{0, 0}},
    '{'{0, 32767, 32767, 32767, 32767, 5'b11111, 0}, 1'b0, '{0, 0}},
    '{'{12000, 11000, 13000, 12500, 11500, 5'b01010, 1000}, 1'b0, '{0, 0}},
    '{'{9472, 9472, 9472, 9472, 9472, 5'b00000, 1048575}, 1'b0, '{0, 0}},
    '{'{1, 0, 32767, 0, 32767, 5'b10101, 0}, 1'b0, '{0, 0}},
    '{'{16384, 16383, 16385, 16384, 16384, 5'b11100, 0}, 1'b0, '{0, 0}},
    '{'{21845, 10922, 21845, 10922, 21845, 5'b10011, 699050}, 1'b0, '{0, 0}}
  };

  bioheat_stencil_cell_update uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_temp_centre       (in_temp_centre),
    .in_temp_row_before   (in_temp_row_before),
    .in_temp_row_after    (in_temp_row_after),
    .in_temp_col_before   (in_temp_col_before),
    .in_temp_col_after    (in_temp_col_after),
    .in_tissue_centre     (in_tissue_centre),
    .in_tissue_row_before (in_tissue_row_before),
    .in_tissue_row_after  (in_tissue_row_after),
    .in_tissue_col_before (in_tissue_col_before),
    .in_tissue_col_after  (in_tissue_col_after),
    .in_nano_heat         (in_nano_heat),
    .out_valid            (out_valid),
    .out_temp_next        (out_temp_next),
    .out_saturated        (out_saturated),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] coef_mask(bsc_pkg::bsc_reg_t idx);
    case (idx)
      bsc_pkg::REG_DIFF_H, bsc_pkg::REG_DIFF_T:
        return {{(32-bsc_pkg::DCOEF_W){1'b0}}, {bsc_pkg::DCOEF_W{1'b1}}};
      bsc_pkg::REG_RATE_H, bsc_pkg::REG_RATE_T:
        return {bsc_pkg::RATE_W{1'b1}};
      bsc_pkg::REG_PERF_H, bsc_pkg::REG_PERF_T:
        return {{(32-bsc_pkg::PERF_W){1'b0}}, {bsc_pkg::PERF_W{1'b1}}};
      default:
        return {{(32-bsc_pkg::STEADY_W){1'b0}}, {bsc_pkg::STEADY_W{1'b1}}};
    endcase
  endfunction

  function automatic logic [31:0] reset_value(bsc_pkg::bsc_reg_t idx);
    case (idx)
      bsc_pkg::REG_DIFF_H:   return 32'(bsc_pkg::RST_DIFF_H);
      bsc_pkg::REG_DIFF_T:   return 32'(bsc_pkg::RST_DIFF_T);
      bsc_pkg::REG_RATE_H:   return 32'(bsc_pkg::RST_RATE_H);
      bsc_pkg::REG_RATE_T:   return 32'(bsc_pkg::RST_RATE_T);
      bsc_pkg::REG_PERF_H:   return 32'(bsc_pkg::RST_PERF_H);
      bsc_pkg::REG_PERF_T:   return 32'(bsc_pkg::RST_PERF_T);
      bsc_pkg::REG_STEADY_H: return 32'(bsc_pkg::RST_STEADY_H);
      default:               return 32'(bsc_pkg::RST_STEADY_T);
    endcase
  endfunction

  function automatic logic [31:0] setting_value(int setting, bsc_pkg::bsc_reg_t idx);
    case (setting)
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      4: begin
        case (idx)
          bsc_pkg::REG_DIFF_H, bsc_pkg::REG_PERF_T, bsc_pkg::REG_STEADY_H: return 32'd0;
          bsc_pkg::REG_RATE_H: return $urandom_range(0, 32'h0400_0000);
          default:             return 32'hFFFF_FFFF;
        endcase
      end
      default: return reset_value(idx);
    endcase
  endfunction

  function automatic longint face_flow(logic [bsc_pkg::DCOEF_W-1:0] k_centre, logic label,
                                       logic [bsc_pkg::TEMP_W-1:0] t_nb,
                                       logic [bsc_pkg::TEMP_W-1:0] t_c);
    logic [63:0] a, b, total, g;
    a = 64'(k_centre);
    b = 64'(label ? coef_shadow[bsc_pkg::REG_DIFF_T] : coef_shadow[bsc_pkg::REG_DIFF_H]);
    total = a + b;
    g = (total == 64'd0) ? 64'd0 : (64'd4 * a * b + total) / (64'd2 * total);
    return longint'(g) * (longint'(t_nb) - longint'(t_c));
  endfunction

  function automatic update_t pennes_update(cell_t c);
    logic [bsc_pkg::DCOEF_W-1:0] k_c;
    logic [63:0]                 rate, perf, steady, m, q;
    longint                      heat, t;
    update_t                     r;
    k_c    = bsc_pkg::DCOEF_W'(c.labels[4] ? coef_shadow[bsc_pkg::REG_DIFF_T]
                                           : coef_shadow[bsc_pkg::REG_DIFF_H]);
    rate   = 64'(c.labels[4] ? coef_shadow[bsc_pkg::REG_RATE_T]
                             : coef_shadow[bsc_pkg::REG_RATE_H]);
    perf   = 64'(c.labels[4] ? coef_shadow[bsc_pkg::REG_PERF_T]
                             : coef_shadow[bsc_pkg::REG_PERF_H]);
    steady = 64'(c.labels[4] ? coef_shadow[bsc_pkg::REG_STEADY_T]
                             : coef_shadow[bsc_pkg::REG_STEADY_H]);
    heat = face_flow(k_c, c.labels[3], c.row_before, c.centre)
         + face_flow(k_c, c.labels[2], c.row_after, c.centre)
         + face_flow(k_c, c.labels[1], c.col_before, c.centre)
         + face_flow(k_c, c.labels[0], c.col_after, c.centre);
    heat += longint'(steady) * 256 - longint'(perf) * longint'(c.centre)
          + longint'(c.nano) * 256;
    m = (heat < 0) ? 64'(-heat) : 64'(heat);
    q = m * (rate >> 16) + ((m * (rate & 64'hFFFF)) >> 16);
    t = longint'((q + 64'h8000_0000) >> 32);
    t = (heat < 0) ? longint'(c.centre) - t : longint'(c.centre) + t;
    r.saturated = (t < 0) || (t > longint'(bsc_pkg::TEMP_MAX));
    r.temp_next = (t < 0) ? '0 : r.saturated ? bsc_pkg::TEMP_MAX : t[bsc_pkg::TEMP_W-1:0];
    return r;
  endfunction

  function automatic logic [bsc_pkg::TEMP_W-1:0] edge_temp();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return bsc_pkg::TEMP_MAX;
      default: return bsc_pkg::TEMP_W'($urandom_range(0, bsc_pkg::TEMP_MAX));
    endcase
  endfunction

  function automatic logic [bsc_pkg::TEMP_W-1:0] near_temp(int centre);
    int v;
    v = centre + int'($urandom_range(0, 512)) - 256;
    if ($urandom_range(0, 3) == 0)
      v = centre;
    return bsc_pkg::TEMP_W'(v);
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    int    mode;
    mode = int'($urandom_range(0, 9));
    c.labels = 5'($urandom_range(0, 31));
    if (mode < 3) begin
      c.centre     = bsc_pkg::TEMP_W'($urandom_range(0, bsc_pkg::TEMP_MAX));
      c.row_before = bsc_pkg::TEMP_W'($urandom_range(0, bsc_pkg::TEMP_MAX));
      c.row_after  = bsc_pkg::TEMP_W'($urandom_range(0, bsc_pkg::TEMP_MAX));
      c.col_before = bsc_pkg::TEMP_W'($urandom_range(0, bsc_pkg::TEMP_MAX));
      c.col_after  = bsc_pkg::TEMP_W'($urandom_range(0, bsc_pkg::TEMP_MAX));
      c.nano       = bsc_pkg::NANO_W'($urandom_range(0, NANO_TOP));
    end else if (mode < 8) begin
      c.centre     = bsc_pkg::TEMP_W'($urandom_range(8000, 12000));
      c.row_before = near_temp(c.centre);
      c.row_after  = near_temp(c.centre);
      c.col_before = near_temp(c.centre);
      c.col_after  = near_temp(c.centre);
      c.nano       = ($urandom_range(0, 3) == 0)
                   ? bsc_pkg::NANO_W'($urandom_range(0, NANO_TOP))
                   : bsc_pkg::NANO_W'($urandom_range(0, 100000));
    end else begin
      c.centre     = edge_temp();
      c.row_before = edge_temp();
      c.row_after  = edge_temp();
      c.col_before = edge_temp();
      c.col_after  = edge_temp();
      c.nano       = $urandom_range(0, 1) ? NANO_TOP : '0;
    end
    return c;
  endfunction

  task automatic send_cell(input cell_t c, input update_t want);
    start                <= 1'b1;
    in_temp_centre       <= c.centre;
    in_temp_row_before   <= c.row_before;
    in_temp_row_after    <= c.row_after;
    in_temp_col_before   <= c.col_before;
    in_temp_col_after    <= c.col_after;
    in_tissue_centre     <= c.labels[4];
    in_tissue_row_before <= c.labels[3];
    in_tissue_row_after  <= c.labels[2];
    in_tissue_col_before <= c.labels[1];
    in_tissue_col_after  <= c.labels[0];
    in_nano_heat         <= c.nano;
    do @(posedge clk); while (busy);
    pending_updates.push_back(want);
    cells_sent++;
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < pct);
    end
  endtask

  task automatic drain_updates();
    start <= 1'b0;
    while (pending_updates.size() != 0)
      @(posedge clk);
    repeat (bsc_pkg::PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_coef(input bsc_pkg::bsc_reg_t idx, input logic [31:0] value);
    while (busy)
      @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    coef_shadow[idx] = value & coef_mask(idx);
    @(posedge clk);
  endtask

  always @(posedge clk) begin : check_updates
    update_t want;
    if (rst_n && out_valid) begin
      if (pending_updates.size() == 0) begin
        mismatch_count++;
        $display("%0t: update with none pending, temp_next=%0d saturated=%0d",
                 $time, out_temp_next, out_saturated);
      end else begin
        want = pending_updates.pop_front();
        updates_checked++;
        if (out_saturated)
          clipped_count++;
        if (out_temp_next !== want.temp_next) begin
          mismatch_count++;
          $display("%0t: temp_next expected %0d, got %0d",
                   $time, want.temp_next, out_temp_next);
        end
        if (out_saturated !== want.saturated) begin
          mismatch_count++;
          $display("%0t: saturated expected %0d, got %0d",
                   $time, want.saturated, out_saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int setting, n, r, idle_pct;
    for (r = 0; r < 8; r++)
      coef_shadow[r] = reset_value(bsc_pkg::bsc_reg_t'(r));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (setting = 0; setting < NUM_SETTINGS; setting++) begin
      idle_pct = (setting < 2) ? 22 : (setting < 4) ? 83 : 0;
      if (setting > 0) begin
        drain_updates();
        for (r = 0; r < 8; r++)
          write_coef(bsc_pkg::bsc_reg_t'(r), setting_value(setting, bsc_pkg::bsc_reg_t'(r)));
      end else begin
        foreach (directed_rows[i]) begin
          sender_gap(idle_pct);
          send_cell(directed_rows[i].stim, directed_rows[i].known ? directed_rows[i].want
                                                                 : pennes_update(directed_rows[i].stim));
        end
      end
      for (n = 0; n < CELLS_PER_SETTING; n++) begin
        cell_t c;
        sender_gap(idle_pct);
        c = random_cell();
        send_cell(c, pennes_update(c));
      end
    end
    drain_updates();
    $display("Sent %0d cells under %0d coefficient settings; %0d updates checked, %0d clipped.",
             cells_sent, NUM_SETTINGS, updates_checked, clipped_count);
    $display("Sender gaps ran at 22 and 83 percent, then back to back.");
    if (mismatch_count == 0 && pending_updates.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
